// ===== rtl/mts_pkg.sv =====
// Package for the min-tracking stack: request and status codes, field widths,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

    // Fixed field widths of the ports
    localparam int FIELD_W       = 32;
    localparam int COUNT_FIELD_W = 9;

    // Request codes; the unused code acts as a status read
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       do_push;
        logic       do_pop;
        logic       fetch_top;
        logic       load_out;
        logic [1:0] status;
    } mts_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
    } mts_stat_t;

endpackage

// ===== rtl/mts_ctrl.sv =====
// Controller of the min-tracking stack: request decode, refill sequencing
// after a pop, and the valid/stall handshake of both channels. Uses mts_pkg.
`timescale 1ns / 1ps

module mts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    output logic              out_valid,
    input  logic              out_stall,
    input  mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t  cmd
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    // Output register frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    // Decode the request and sequence the top refill
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_PUSH:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.do_push = 1'b1;
                            end
                        end
                        REQ_POP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status   = ST_EMPTY;
                                cmd.load_out = 1'b1;
                            end
                            else if (stat.single)
                            begin
                                cmd.do_pop   = 1'b1;
                                cmd.load_out = 1'b1;
                            end
                            else
                            begin
                                cmd.do_pop = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            cmd.load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.fetch_top = 1'b1;
                cmd.load_out  = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A refill cycle always finds the output register empty
    a_fetch_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !out_valid_reg)
        else $error("refill cycle with output register occupied");

    // A refill returns to idle on the next cycle and delivers a beat
    a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("refill did not complete");

    // A pop of a deeper stack always goes through a refill
    a_pop_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_POP) && !stat.empty && !stat.single)
        |=> (state_reg == S_FETCH))
        else $error("pop skipped top refill");

endmodule

// ===== rtl/mts_dpath.sv =====
// Datapath of the min-tracking stack: cached top entry, memory of the entries
// beneath it, entry counter and result registers. Uses mts_pkg.
`timescale 1ns / 1ps

module mts_dpath
#(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mts_pkg::mts_cmd_t                   cmd,
    input  logic signed [mts_pkg::FIELD_W-1:0]  push_value,
    output mts_pkg::mts_stat_t                  stat,
    output logic signed [mts_pkg::FIELD_W-1:0]  top_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  min_value,
    output logic [mts_pkg::COUNT_FIELD_W-1:0]   entry_count,
    output logic                                is_empty,
    output logic [1:0]                          status
);
    import mts_pkg::*;

    localparam int StoreW = (WORD_WIDTH < FIELD_W) ? WORD_WIDTH : FIELD_W;
    localparam int CntW   = $clog2(STACK_DEPTH + 1);
    localparam int AddrW  = $clog2(STACK_DEPTH);

    // Entries beneath the cached top
    logic [StoreW-1:0] val_mem [STACK_DEPTH];
    logic [StoreW-1:0] min_mem [STACK_DEPTH];

    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic [CntW-1:0]   count_m1;
    logic [CntW-1:0]   count_m2;
    logic [StoreW-1:0] top_val_reg;
    logic [StoreW-1:0] top_val_next;
    logic [StoreW-1:0] top_min_reg;
    logic [StoreW-1:0] top_min_next;
    logic [StoreW-1:0] rd_val_reg;
    logic [StoreW-1:0] rd_min_reg;
    logic [StoreW-1:0] push_word;
    logic [StoreW-1:0] new_min;

    logic signed [FIELD_W-1:0] out_top_reg;
    logic signed [FIELD_W-1:0] out_min_reg;
    logic [CntW-1:0]           out_count_reg;
    logic                      out_empty_reg;
    logic [1:0]                out_status_reg;
    logic [CntW+COUNT_FIELD_W-1:0] count_ext;

    assign count_m1 = count_reg - CntW'(1);
    assign count_m2 = count_reg - CntW'(2);

    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CntW'(STACK_DEPTH));
    assign stat.single = (count_reg == CntW'(1));

    // Keep the low bits of the pushed word; fold in the minimum beneath
    assign push_word = push_value[StoreW-1:0];
    assign new_min   = (!stat.empty && !($signed(push_word) < $signed(top_min_reg)))
                       ? top_min_reg : push_word;

    // Next counter and cached top
    always_comb
    begin
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        if (cmd.do_push)
        begin
            count_next   = count_reg + CntW'(1);
            top_val_next = push_word;
            top_min_next = new_min;
        end
        if (cmd.do_pop)
        begin
            count_next = count_m1;
        end
        if (cmd.fetch_top)
        begin
            top_val_next = rd_val_reg;
            top_min_next = rd_min_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
    end

    // Spill the old top on push; read the new top on pop
    always_ff @(posedge clk)
    begin
        if (cmd.do_push && !stat.empty)
        begin
            val_mem[count_m1[AddrW-1:0]] <= top_val_reg;
            min_mem[count_m1[AddrW-1:0]] <= top_min_reg;
        end
        if (cmd.do_pop)
        begin
            rd_val_reg <= val_mem[count_m2[AddrW-1:0]];
            rd_min_reg <= min_mem[count_m2[AddrW-1:0]];
        end
    end

    // Capture the result beat from the state after the operation
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_top_reg    <= (count_next == '0) ? '0 : FIELD_W'($signed(top_val_next));
            out_min_reg    <= (count_next == '0) ? '0 : FIELD_W'($signed(top_min_next));
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
            out_status_reg <= cmd.status;
        end
    end

    assign count_ext   = {{COUNT_FIELD_W{1'b0}}, out_count_reg};
    assign top_value   = out_top_reg;
    assign min_value   = out_min_reg;
    assign entry_count = count_ext[COUNT_FIELD_W-1:0];
    assign is_empty    = out_empty_reg;
    assign status      = out_status_reg;

    // Counter stays within the stack depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(STACK_DEPTH))
        else $error("entry count beyond depth");

    // Never push onto a full stack or pop an empty one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_push && stat.full) && !(cmd.do_pop && stat.empty))
        else $error("stack overrun or underrun");

    // A refill follows a pop directly
    a_fetch_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch_top |-> $past(cmd.do_pop))
        else $error("refill without preceding pop");

endmodule

// ===== rtl/min_tracking_stack.sv =====
// Top level of the min-tracking stack: joins controller and datapath.
// Depends on mts_pkg, mts_ctrl and mts_dpath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_stall  | req_type, push_value
//   out     | output    | out_valid / out_stall| top_value, min_value, entry_count,
//           |           |                      | is_empty, status
//
// Push, pop down to empty, and status reads load the result at once; a pop that
// leaves entries adds a refill state, as the new top comes back over the memory read port.
// The top entry is cached in registers, the rest sit in a single-port memory.
// Reset clears entry count, controller state and output valid; memory needs no clearing.
// A waiting result holds the output register; input stalls only when that
// register is full and not being taken, or during a pop refill.
`timescale 1ns / 1ps

module min_tracking_stack
#(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic signed [mts_pkg::FIELD_W-1:0]  push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mts_pkg::FIELD_W-1:0]  top_value,
    output logic signed [mts_pkg::FIELD_W-1:0]  min_value,
    output logic [mts_pkg::COUNT_FIELD_W-1:0]   entry_count,
    output logic                                is_empty,
    output logic [1:0]                          status
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mts_dpath
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .push_value  (push_value),
        .stat        (stat),
        .top_value   (top_value),
        .min_value   (min_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

endmodule

// ===== bench/min_tracking_stack_test.sv =====
// Self-checking bench for min_tracking_stack: drives push, pop and read beats,
// predicts every result beat from a shadow stack and compares field by field.
// Depends on mts_pkg and the min_tracking_stack RTL.
`timescale 1ns / 1ps

module min_tracking_stack_test;

    import mts_pkg::*;

    localparam int STACK_DEPTH  = 256;
    localparam int WORD_WIDTH   = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 40;
    localparam int HOLD_CYCLES  = 120;

    // Unused request code, acts as a status read
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic signed [FIELD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Snapshot of the stack that one result beat reports
    typedef struct packed {
        logic signed [FIELD_W-1:0] top;
        logic signed [FIELD_W-1:0] low;
        logic [COUNT_FIELD_W-1:0]  count;
        logic                      empty;
        logic [1:0]                code;
    } stack_view_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  req_type;
    logic signed [FIELD_W-1:0]   push_value;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [FIELD_W-1:0]   top_value;
    logic signed [FIELD_W-1:0]   min_value;
    logic [COUNT_FIELD_W-1:0]    entry_count;
    logic                        is_empty;
    logic [1:0]                  status;

    // Shadow stack and the snapshots still owed by the block
    logic signed [FIELD_W-1:0]   shadow_vals [STACK_DEPTH];
    logic signed [FIELD_W-1:0]   shadow_mins [STACK_DEPTH];
    int                          shadow_depth = 0;
    stack_view_t                 owed_views [$];

    int mismatch_count = 0;
    int burst_left     = 0;
    bit pace_on        = 1'b1;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_mode     = 0;
    int rx_cycle       = 0;

    always #2 clk = ~clk;

    min_tracking_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_value   (top_value),
        .min_value   (min_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    // Apply one accepted beat to the shadow stack and queue the snapshot it yields
    task automatic apply_stack_op(input logic [1:0] req, input logic signed [FIELD_W-1:0] word);
        stack_view_t               view;
        logic signed [FIELD_W-1:0] floor_min;
        view = '0;
        view.code = ST_OK;
        case (req)
            REQ_PUSH:
            begin
                if (shadow_depth == STACK_DEPTH)
                begin
                    view.code = ST_FULL;
                end
                else
                begin
                    floor_min = word;
                    if (shadow_depth > 0 && shadow_mins[shadow_depth - 1] < word)
                        floor_min = shadow_mins[shadow_depth - 1];
                    shadow_vals[shadow_depth] = word;
                    shadow_mins[shadow_depth] = floor_min;
                    shadow_depth++;
                end
            end
            REQ_POP:
            begin
                if (shadow_depth == 0)
                    view.code = ST_EMPTY;
                else
                    shadow_depth--;
            end
            default:
            begin
            end
        endcase
        if (shadow_depth > 0)
        begin
            view.top = shadow_vals[shadow_depth - 1];
            view.low = shadow_mins[shadow_depth - 1];
        end
        view.count = shadow_depth[COUNT_FIELD_W-1:0];
        view.empty = (shadow_depth == 0);
        owed_views.push_back(view);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Offer one beat, hold it until taken, then predict its result
    task automatic send_beat(input logic [1:0] req, input logic signed [FIELD_W-1:0] word);
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= req;
        push_value <= word;
        do
            @(posedge clk);
        while (in_stall);
        apply_stack_op(req, word);
    endtask

    // Lower valid and wait until every owed result has come back
    task automatic wait_for_results();
        idle_cycles(1);
        while (owed_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mix of full-range words, small words that tie often, and extremes
    function automatic logic signed [FIELD_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom;
        else if (pick < 80)
            return $signed($urandom_range(0, 16)) - 8;
        else
        begin
            case ($urandom_range(0, 3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
    endfunction

    function automatic logic [1:0] pick_request(input int push_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_weight)
            return REQ_PUSH;
        else if (r < push_weight + ((100 - push_weight) * 3) / 4)
            return REQ_POP;
        else if (r % 2 == 0)
            return REQ_READ;
        else
            return REQ_SPARE;
    endfunction

    // Stall the result side on a changing pattern; honor long hold-offs
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= ($urandom_range(0, 99) < 70);
                default: out_stall <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // Compare each taken result beat with the oldest owed snapshot
    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_views.size() == 0)
            begin
                report_mismatch("result beat with nothing owed");
            end
            else
            begin
                want = owed_views.pop_front();
                if (top_value !== want.top)
                    report_mismatch($sformatf("top_value got %0d want %0d",
                                              top_value, want.top));
                if (min_value !== want.low)
                    report_mismatch($sformatf("min_value got %0d want %0d",
                                              min_value, want.low));
                if (entry_count !== want.count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              entry_count, want.count));
                if (is_empty !== want.empty)
                    report_mismatch($sformatf("is_empty got %b want %b",
                                              is_empty, want.empty));
                if (status !== want.code)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.code));
            end
        end
    end

    // Pop, read and spare code on an empty stack
    task automatic test_empty_stack();
        send_beat(REQ_POP, $urandom);
        send_beat(REQ_READ, $urandom);
        send_beat(REQ_SPARE, $urandom);
        send_beat(REQ_POP, '0);
    endtask

    // Extreme words, ties on the minimum, and a pop back down to empty
    task automatic test_extreme_words();
        send_beat(REQ_PUSH, WORD_MAX);
        send_beat(REQ_PUSH, WORD_MIN);
        send_beat(REQ_PUSH, '0);
        send_beat(REQ_PUSH, '1);
        send_beat(REQ_PUSH, WORD_MIN);
        send_beat(REQ_READ, '1);
        repeat (5) send_beat(REQ_POP, $urandom);
        send_beat(REQ_POP, WORD_MAX);
        send_beat(REQ_SPARE, '1);
        send_beat(REQ_PUSH, 32'sd5);
        send_beat(REQ_PUSH, 32'sd5);
        send_beat(REQ_PUSH, 32'sd3);
        send_beat(REQ_PUSH, 32'sd9);
        repeat (4) send_beat(REQ_POP, '0);
    endtask

    // Fill to the last entry, push onto a full stack, then empty it again
    task automatic test_full_stack();
        while (shadow_depth > 0)
            send_beat(REQ_POP, $urandom);
        while (shadow_depth < STACK_DEPTH)
            send_beat(REQ_PUSH, random_word());
        send_beat(REQ_PUSH, WORD_MIN);
        send_beat(REQ_PUSH, $urandom);
        send_beat(REQ_READ, $urandom);
        send_beat(REQ_SPARE, $urandom);
        while (shadow_depth > 0)
            send_beat(REQ_POP, $urandom);
        send_beat(REQ_POP, $urandom);
    endtask

    // Hold off the result side for a long stretch while beats keep coming
    task automatic test_output_hold_off();
        int i;
        wait_for_results();
        pace_on = 1'b0;
        hold_seq++;
        for (i = 0; i < 40; i++)
            send_beat(pick_request(60), random_word());
        pace_on = 1'b1;
        wait_for_results();
    endtask

    // Random phases, each with its own push bias and pacing
    task automatic test_random_phases();
        int phase;
        int i;
        int push_weight;
        for (phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       push_weight = 20;
                1:       push_weight = 50;
                2:       push_weight = 65;
                default: push_weight = 90;
            endcase
            pace_on = (phase % 3 != 2);
            for (i = 0; i < 10; i++)
                send_beat(pick_request(push_weight), random_word());
            if (phase == 3)
                wait_for_results();
        end
        pace_on = 1'b1;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_READ;
        push_value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_extreme_words();
        test_full_stack();
        test_output_hold_off();
        test_random_phases();
        wait_for_results();

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // End a hung run
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
